@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/bfls_pkg.sv @@
// shared constants and types of the batched free-list stack
package bfls_pkg;

    localparam int NUM_OBJECTS = 1024;
    localparam int ADDR_W      = $clog2(NUM_OBJECTS);
    localparam int PTR_W       = $clog2(NUM_OBJECTS + 1);
    localparam int OBJ_W       = 10;
    localparam int LEN_W       = 10;
    localparam int CNT_W       = 11;

    localparam logic [PTR_W-1:0] NONE_PTR        = PTR_W'(NUM_OBJECTS);
    localparam logic [LEN_W-1:0] BATCH_LIMIT_RST = LEN_W'(15);

    localparam logic OP_POP  = 1'b0;
    localparam logic OP_PUSH = 1'b1;

    // one node of the free list as held in memory
    typedef struct packed {
        logic [PTR_W-1:0] olink;
        logic [PTR_W-1:0] blink;
        logic [LEN_W-1:0] len;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    typedef struct packed {
        logic accept;
        logic fetch;
    } t_cmd;

    typedef struct packed {
        logic pop_hit;
    } t_status;

endpackage

@@ src/bfls_ram.sv @@
// generic single-write, single-read ram with registered read data
module bfls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/bfls_ctrl.sv @@
// controller: handshake and head refill sequencing
module bfls_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  bfls_pkg::t_status i_sts,
    output bfls_pkg::t_cmd   o_cmd
);
    import bfls_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (accept) begin
            n_out_valid = 1'b1;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_sts.pop_hit) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cmd.accept = accept;
    assign o_cmd.fetch  = (r_state == ST_FETCH);

endmodule

@@ src/bfls_dp.sv @@
// datapath: head pointer, cached head node, counters, node memory
module bfls_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bfls_pkg::t_cmd           i_cmd,
    output bfls_pkg::t_status        o_sts,
    input  logic                     i_op,
    input  logic [bfls_pkg::OBJ_W-1:0] i_obj,
    input  logic                     i_cfg_we,
    input  logic [bfls_pkg::LEN_W-1:0] i_cfg_data,
    output logic [bfls_pkg::OBJ_W-1:0] o_popped,
    output logic                     o_was_empty,
    output logic [bfls_pkg::CNT_W-1:0] o_free,
    output logic [bfls_pkg::CNT_W-1:0] o_batches
);
    import bfls_pkg::*;

    logic [LEN_W-1:0] r_batch_limit;
    logic [PTR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_free, n_free;
    logic [CNT_W-1:0] r_batches, n_batches;
    t_node            r_cache, n_cache;

    logic [OBJ_W-1:0] r_popped, n_popped;
    logic             r_was_empty, n_was_empty;
    logic [CNT_W-1:0] r_out_free, r_out_batches;

    logic             head_valid;
    logic             pop_empty;
    logic [PTR_W-1:0] obj_ext;
    logic             push_ok;
    logic             grow;
    t_node            new_node;
    t_node            rd_node;
    logic             ram_we;
    logic             ram_re;
    logic [PTR_W-1:0] next_head;

    assign head_valid = (r_head < NONE_PTR);
    assign pop_empty  = !head_valid || (r_free == '0);
    assign obj_ext    = PTR_W'(i_obj);
    assign push_ok    = (obj_ext < NONE_PTR) && (r_free < CNT_W'(NUM_OBJECTS));
    assign grow       = head_valid && (r_cache.len < r_batch_limit);

    assign o_sts.pop_hit = (i_op == OP_POP) && !pop_empty;

    always_comb begin
        new_node.olink = grow ? r_head : NONE_PTR;
        new_node.blink = grow ? NONE_PTR : r_head;
        new_node.len   = grow ? r_cache.len + 1'b1 : '0;
        // follow the object link, or the batch link at a batch's last node
        if (r_cache.olink < NONE_PTR) begin
            next_head = r_cache.olink;
        end else if (r_cache.blink < NONE_PTR) begin
            next_head = r_cache.blink;
        end else begin
            next_head = NONE_PTR;
        end
    end

    always_comb begin
        n_head      = r_head;
        n_free      = r_free;
        n_batches   = r_batches;
        n_cache     = r_cache;
        n_popped    = r_popped;
        n_was_empty = r_was_empty;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        if (i_cmd.fetch) begin
            n_cache = rd_node;
        end
        if (i_cmd.accept) begin
            n_popped    = '0;
            n_was_empty = 1'b0;
            unique case (i_op)
                OP_PUSH: begin
                    if (push_ok) begin
                        ram_we  = 1'b1;
                        n_head  = obj_ext;
                        n_cache = new_node;
                        n_free  = r_free + 1'b1;
                        if (!grow) begin
                            n_batches = r_batches + 1'b1;
                        end
                    end
                end
                OP_POP: begin
                    if (pop_empty) begin
                        n_was_empty = 1'b1;
                    end else begin
                        ram_re   = 1'b1;
                        n_popped = OBJ_W'(r_head);
                        n_head   = next_head;
                        n_free   = r_free - 1'b1;
                        if (!(r_cache.olink < NONE_PTR) && (r_batches != '0)) begin
                            n_batches = r_batches - 1'b1;
                        end
                    end
                end
                default: begin
                    n_popped = '0;
                end
            endcase
        end
    end

    bfls_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NUM_OBJECTS)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (obj_ext[ADDR_W-1:0]),
        .i_wdata (new_node),
        .i_re    (ram_re),
        .i_raddr (next_head[ADDR_W-1:0]),
        .o_rdata (rd_node)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_limit <= BATCH_LIMIT_RST;
            r_head        <= NONE_PTR;
            r_free        <= '0;
            r_batches     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_batch_limit <= i_cfg_data;
            end
            r_head    <= n_head;
            r_free    <= n_free;
            r_batches <= n_batches;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cache     <= n_cache;
        r_popped    <= n_popped;
        r_was_empty <= n_was_empty;
        if (i_cmd.accept) begin
            r_out_free    <= n_free;
            r_out_batches <= n_batches;
        end
    end

    assign o_popped    = r_popped;
    assign o_was_empty = r_was_empty;
    assign o_free      = r_out_free;
    assign o_batches   = r_out_batches;

endmodule

@@ src/batched_free_list_stack.sv @@
// top level of the batched free-list stack
//
//  channel   | dir | beat carries
//  s_axis    | in  | tuser: op (0 pop, 1 push); tdata: object_index
//  m_axis    | out | tuser: was_empty; tdata: popped_index, free_count, batch_count
//  cfg       | in  | data: batch_limit
//
// a popped object is followed by a refill state that takes no beat: the new
// head node is read from the node ram (one read port, registered data)
// a push, an empty pop or an ignored push needs no refill state
// reset is synchronous and active low; the node ram needs no clearing pass
// the next beat is taken while a result waits, unless that result is stalled
// config writes are taken every cycle and must only come while the block is idle
module batched_free_list_stack (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] object_index, [15:10] zero
    input  logic [0:0]  s_axis_tuser,   // [0] op
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [9:0] popped_index, [20:10] free_count,
                                        // [31:21] batch_count
    output logic [0:0]  m_axis_tuser,   // [0] was_empty
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [bfls_pkg::LEN_W-1:0] i_cfg_data
);
    import bfls_pkg::*;

    t_cmd             cmd;
    t_status          sts;
    logic [OBJ_W-1:0] popped;
    logic             was_empty;
    logic [CNT_W-1:0] free_cnt;
    logic [CNT_W-1:0] batch_cnt;

    // config register is always writable
    assign o_cfg_ready = 1'b1;

    bfls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bfls_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (s_axis_tuser[0]),
        .i_obj       (s_axis_tdata[OBJ_W-1:0]),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_popped    (popped),
        .o_was_empty (was_empty),
        .o_free      (free_cnt),
        .o_batches   (batch_cnt)
    );

    // result beat packing, first field in the low bits
    assign m_axis_tdata = {batch_cnt, free_cnt, popped};
    assign m_axis_tuser = was_empty;

endmodule

@@ src/bfls_checker.sv @@
// port-level checker for the batched free-list stack, bound to the top level
`include "assert_macros.svh"

module bfls_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    logic out_stall;
    logic in_beat;
    logic empty_beat;

    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign in_beat    = s_axis_tvalid && s_axis_tready;
    assign empty_beat = m_axis_tvalid && m_axis_tuser[0];

    // stalled result beat holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
    // every accepted item yields a result beat on the next cycle
    `ASSERT_NEXT(a_in_to_out, i_clk, i_rst_n, in_beat, m_axis_tvalid)
    // no item is taken while the result slot is blocked
    `ASSERT_IMPLIES(a_no_overrun, i_clk, i_rst_n, out_stall, !s_axis_tready)
    // an empty pop hands out no object
    `ASSERT_IMPLIES(a_empty_zero, i_clk, i_rst_n, empty_beat, m_axis_tdata[9:0] == 10'd0)

endmodule

bind batched_free_list_stack bfls_checker u_bfls_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
